// File: hdl/cagnms_pkg.sv
`default_nettype none
package cagnms_pkg;

  localparam int unsigned KeptDepth = 512;
  localparam int unsigned CoordBits = 16;
  localparam int unsigned IdxBits   = $clog2(KeptDepth);
  localparam int unsigned CntBits   = $clog2(KeptDepth + 1);
  localparam int unsigned ClassBits = 7;
  localparam int unsigned ThrBits   = 9;
  localparam int unsigned LimBits   = 10;
  localparam int unsigned ConfBits  = 16;
  localparam int unsigned AddrBits  = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ThrBits-1:0] ThrReset = 9'd179;
  localparam logic [LimBits-1:0] LimReset = 10'd300;

  localparam logic [AddrBits-1:0] RegThr = 3'd0;
  localparam logic [AddrBits-1:0] RegLim = 3'd4;

  typedef struct packed {
    logic [CoordBits-1:0] box_left;
    logic [CoordBits-1:0] box_top;
    logic [CoordBits-1:0] box_right;
    logic [CoordBits-1:0] box_bottom;
    logic [ClassBits-1:0] class_index;
    logic [ConfBits-1:0]  confidence;
    logic                 frame_end;
  } in_word_t;

  typedef struct packed {
    logic                 kept;
    logic [CoordBits-1:0] out_left;
    logic [CoordBits-1:0] out_top;
    logic [CoordBits-1:0] out_right;
    logic [CoordBits-1:0] out_bottom;
    logic [ClassBits-1:0] out_class;
    logic [ConfBits-1:0]  out_confidence;
    logic [LimBits-1:0]   kept_count;
    logic                 last_of_frame;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_AREA,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

// File: hdl/cagnms_queue.sv
`default_nettype none
module cagnms_queue (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  wire cagnms_pkg::in_word_t data_i,
  output logic                      full_o,
  input  wire                       pop_i,
  output cagnms_pkg::in_word_t      data_o,
  output logic                      empty_o
);

  localparam int unsigned PtrBits = $clog2(cagnms_pkg::QueueDepth);

  cagnms_pkg::in_word_t mem_q [cagnms_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (PtrBits+1)'(cagnms_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrBits+1)'(cagnms_pkg::QueueDepth)) else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |=> !($past(cnt_q) == '0 && cnt_q > 1)) else $error("queue count jump");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full dropped without pop");

endmodule
`default_nettype wire

// File: hdl/cagnms_engine.sv
`default_nettype none
module cagnms_engine (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [cagnms_pkg::ThrBits-1:0]     thr_i,
  input  wire  [cagnms_pkg::LimBits-1:0]     lim_i,
  input  wire  cagnms_pkg::in_word_t         item_i,
  input  wire                                item_valid_i,
  output logic                               item_take_o,
  output cagnms_pkg::out_word_t              res_o,
  output logic                               res_valid_o,
  input  wire                                res_pop_i
);

  localparam int unsigned CB = cagnms_pkg::CoordBits;
  localparam int unsigned IB = cagnms_pkg::IdxBits;
  localparam int unsigned NB = cagnms_pkg::CntBits;
  // signed widths: coord diff CB+2, product 2*CB+4, union/compare wider
  localparam int unsigned DB = CB + 2;
  localparam int unsigned PB = 2 * DB;
  localparam int unsigned UB = PB + 2;
  localparam int unsigned TB = UB + cagnms_pkg::ThrBits + 2;

  cagnms_pkg::state_e state_q, state_d;

  logic [4*CB-1:0]                   corner_mem [cagnms_pkg::KeptDepth];
  logic [cagnms_pkg::ClassBits-1:0]  class_mem  [cagnms_pkg::KeptDepth];
  logic [4*CB-1:0]                   rd_corner_q;
  logic [cagnms_pkg::ClassBits-1:0]  rd_class_q;

  cagnms_pkg::in_word_t cur_q;
  logic [NB-1:0] total_q, total_d, scan_q, scan_d;
  logic [NB-1:0] limit;
  logic          keep_q, keep_d;
  logic          res_valid_q;
  cagnms_pkg::out_word_t res_q;
  logic          rd_en, wr_en;

  logic signed [PB-1:0] inter_q, area_b_q, area_a_q;
  logic                 hit_q;
  logic signed [UB-1:0] uni_q;
  logic signed [DB-1:0] ix1, iy1, ix2, iy2, iw, ih;
  logic signed [DB-1:0] bl, bt, br, bb;
  logic signed [UB-1:0] uni_d;
  logic signed [TB-1:0] lhs, rhs;
  logic                 supp;

  always_comb begin
    limit = (lim_i == '0) ? NB'(1) : NB'(lim_i);
    if (limit > NB'(cagnms_pkg::KeptDepth)) limit = NB'(cagnms_pkg::KeptDepth);
  end

  assign bl = DB'(rd_corner_q[4*CB-1 -: CB]);
  assign bt = DB'(rd_corner_q[3*CB-1 -: CB]);
  assign br = DB'(rd_corner_q[2*CB-1 -: CB]);
  assign bb = DB'(rd_corner_q[CB-1 -: CB]);

  always_comb begin
    ix1 = (DB'(cur_q.box_left) > bl) ? DB'(cur_q.box_left) : bl;
    iy1 = (DB'(cur_q.box_top) > bt) ? DB'(cur_q.box_top) : bt;
    ix2 = (DB'(cur_q.box_right) < br) ? DB'(cur_q.box_right) : br;
    iy2 = (DB'(cur_q.box_bottom) < bb) ? DB'(cur_q.box_bottom) : bb;
    iw  = ix2 - ix1;
    ih  = iy2 - iy1;
    uni_d = UB'(area_a_q) + UB'(area_b_q) - UB'(inter_q);
    lhs = TB'(inter_q) <<< 8;
    rhs = TB'($signed({1'b0, thr_i})) * TB'(uni_q);
    supp = hit_q && (uni_q > 0) && (lhs > rhs);
  end

  assign rd_en = (state_q == cagnms_pkg::ST_READ) && (scan_q < total_q);
  assign wr_en = (state_q == cagnms_pkg::ST_DONE) && keep_q && !res_valid_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_corner_q <= corner_mem[scan_q[IB-1:0]];
      rd_class_q  <= class_mem[scan_q[IB-1:0]];
    end
    if (wr_en) begin
      corner_mem[total_q[IB-1:0]] <= {cur_q.box_left, cur_q.box_top,
                                      cur_q.box_right, cur_q.box_bottom};
      class_mem[total_q[IB-1:0]]  <= cur_q.class_index;
    end
  end

  // overlap pipeline, one kept entry at a time
  always_ff @(posedge clk_i) begin
    if (item_take_o) cur_q <= item_i;
    if (state_q == cagnms_pkg::ST_IDLE && item_valid_i)
      area_a_q <= (DB'(item_i.box_right) - DB'(item_i.box_left)) *
                  (DB'(item_i.box_bottom) - DB'(item_i.box_top));
    if (state_q == cagnms_pkg::ST_MUL) begin
      hit_q    <= (rd_class_q == cur_q.class_index) && (iw > 0) && (ih > 0);
      inter_q  <= iw * ih;
      area_b_q <= (br - bl) * (bb - bt);
    end
    if (state_q == cagnms_pkg::ST_AREA) uni_q <= uni_d;
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    keep_d      = keep_q;
    total_d     = total_q;
    item_take_o = 1'b0;
    case (state_q)
      cagnms_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          scan_d      = '0;
          keep_d      = (total_q < limit);
          state_d     = cagnms_pkg::ST_READ;
        end
      end
      cagnms_pkg::ST_READ: begin
        if (!keep_q || scan_q >= total_q) state_d = cagnms_pkg::ST_DONE;
        else state_d = cagnms_pkg::ST_MUL;
      end
      cagnms_pkg::ST_MUL:  state_d = cagnms_pkg::ST_AREA;
      cagnms_pkg::ST_AREA: state_d = cagnms_pkg::ST_CMP;
      cagnms_pkg::ST_CMP: begin
        if (supp) keep_d = 1'b0;
        scan_d  = scan_q + 1'b1;
        state_d = cagnms_pkg::ST_READ;
      end
      cagnms_pkg::ST_DONE: begin
        if (!res_valid_q) begin
          if (keep_q) total_d = total_q + 1'b1;
          if (cur_q.frame_end) total_d = '0;
          state_d = cagnms_pkg::ST_IDLE;
        end
      end
      default: state_d = cagnms_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cagnms_pkg::ST_DONE && !res_valid_q) begin
      res_q.kept           <= keep_q;
      res_q.out_left       <= cur_q.box_left;
      res_q.out_top        <= cur_q.box_top;
      res_q.out_right      <= cur_q.box_right;
      res_q.out_bottom     <= cur_q.box_bottom;
      res_q.out_class      <= cur_q.class_index;
      res_q.out_confidence <= cur_q.confidence;
      res_q.kept_count     <= cagnms_pkg::LimBits'(keep_q ? total_q + 1'b1 : total_q);
      res_q.last_of_frame  <= cur_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cagnms_pkg::ST_IDLE;
      scan_q      <= '0;
      keep_q      <= 1'b0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      keep_q  <= keep_d;
      total_q <= total_d;
      if (state_q == cagnms_pkg::ST_DONE && !res_valid_q) res_valid_q <= 1'b1;
      else if (res_pop_i) res_valid_q <= 1'b0;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= NB'(cagnms_pkg::KeptDepth)) else $error("kept total overflow");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cagnms_pkg::ST_MUL |-> scan_q < total_q) else $error("scan past total");
  a_keep_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cagnms_pkg::ST_IDLE && state_q != cagnms_pkg::ST_DONE && !keep_q)
      |=> !keep_q) else $error("keep flag revived");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o |-> state_q == cagnms_pkg::ST_IDLE) else $error("take while busy");

endmodule
`default_nettype wire

// File: hdl/class_aware_greedy_nms_core.sv
// the engine takes a new word only once done with the last one; its kept-box scan
// over one memory port sets the pace
// a two-word input queue and a result register let each side stall on its own
// reset: async active low; clears control, count and registers to 179 and 300
// kept-box memories are not cleared; only entries written this frame are read
`default_nettype none
module class_aware_greedy_nms_core (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push,
  input  wire cagnms_pkg::in_word_t in_data_i,
  output logic                   full,
  output logic                   empty,
  input  wire                    pop,
  output cagnms_pkg::out_word_t  out_data_o,
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [cagnms_pkg::AddrBits-1:0] paddr,
  input  wire  [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [cagnms_pkg::ThrBits-1:0] thr_q;
  logic [cagnms_pkg::LimBits-1:0] lim_q;
  cagnms_pkg::in_word_t q_data;
  logic q_empty, q_pop, res_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= cagnms_pkg::ThrReset;
      lim_q <= cagnms_pkg::LimReset;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        cagnms_pkg::RegThr: thr_q <= pwdata[cagnms_pkg::ThrBits-1:0];
        cagnms_pkg::RegLim: lim_q <= pwdata[cagnms_pkg::LimBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      cagnms_pkg::RegThr: prdata = 32'(thr_q);
      cagnms_pkg::RegLim: prdata = 32'(lim_q);
      default:            prdata = '0;
    endcase
  end

  cagnms_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(in_data_i), .full_o(full),
    .pop_i(q_pop), .data_o(q_data), .empty_o(q_empty)
  );

  cagnms_engine u_engine (
    .clk_i, .rst_ni,
    .thr_i(thr_q), .lim_i(lim_q),
    .item_i(q_data), .item_valid_i(!q_empty), .item_take_o(q_pop),
    .res_o(out_data_o), .res_valid_o(res_valid), .res_pop_i(pop)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

// File: sim/testbench.sv
`default_nettype none
module testbench;

  localparam int CB = cagnms_pkg::CoordBits;
  localparam int KB = cagnms_pkg::ClassBits;
  localparam int FB = cagnms_pkg::ConfBits;
  localparam int AB = cagnms_pkg::AddrBits;
  localparam int HB = cagnms_pkg::ThrBits;
  localparam int LB = cagnms_pkg::LimBits;
  localparam int KD = cagnms_pkg::KeptDepth;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  cagnms_pkg::in_word_t in_data_i = '0;
  logic full, empty;
  logic pop = 1'b0;
  cagnms_pkg::out_word_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AB-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  class_aware_greedy_nms_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .in_data_i(in_data_i), .full(full),
    .empty(empty), .pop(pop), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int WatchLimit = 400000;

  typedef struct {
    logic [CB-1:0] l, t, r, b;
    logic [KB-1:0] c;
  } box_t;

  cagnms_pkg::in_word_t  box_queue[$];
  cagnms_pkg::out_word_t verdict_queue[$];
  box_t      kept_boxes[KD];
  int unsigned kept_n;
  logic [HB-1:0] thr_q;
  logic [LB-1:0] lim_q;
  int errors;
  int stall_cycles;
  int gap_cycles;
  int hold_rx;
  int idle_count;
  logic send_done;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic bit box_overlaps(input box_t a, input box_t b);
    longint ix1, iy1, ix2, iy2, iw, ih, inter, aa, ab, uni;
    ix1 = (a.l > b.l) ? a.l : b.l;
    iy1 = (a.t > b.t) ? a.t : b.t;
    ix2 = (a.r < b.r) ? a.r : b.r;
    iy2 = (a.b < b.b) ? a.b : b.b;
    iw = ix2 - ix1;
    ih = iy2 - iy1;
    if (iw <= 0 || ih <= 0) return 1'b0;
    inter = iw * ih;
    aa = (longint'(a.r) - longint'(a.l)) * (longint'(a.b) - longint'(a.t));
    ab = (longint'(b.r) - longint'(b.l)) * (longint'(b.b) - longint'(b.t));
    uni = aa + ab - inter;
    if (uni <= 0) return 1'b0;
    return inter * 256 > longint'(thr_q) * uni;
  endfunction

  function automatic cagnms_pkg::out_word_t suppress_box(input cagnms_pkg::in_word_t w);
    cagnms_pkg::out_word_t o;
    box_t bx;
    int unsigned limit;
    bit keep;
    bx.l = w.box_left; bx.t = w.box_top; bx.r = w.box_right; bx.b = w.box_bottom;
    bx.c = w.class_index;
    limit = 32'(lim_q);
    if (limit == 0) limit = 1;
    if (limit > KD) limit = KD;
    keep = 1'b0;
    if (kept_n < limit) begin
      keep = 1'b1;
      for (int j = 0; j < kept_n; j++) begin
        if (kept_boxes[j].c == bx.c && box_overlaps(bx, kept_boxes[j])) begin
          keep = 1'b0;
          break;
        end
      end
      if (keep) begin
        kept_boxes[kept_n] = bx;
        kept_n++;
      end
    end
    o.kept = keep;
    o.out_left = w.box_left;
    o.out_top = w.box_top;
    o.out_right = w.box_right;
    o.out_bottom = w.box_bottom;
    o.out_class = w.class_index;
    o.out_confidence = w.confidence;
    o.kept_count = kept_n[LB-1:0];
    o.last_of_frame = w.frame_end;
    if (w.frame_end) kept_n = 0;
    return o;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: one word offered at a time, prediction made at acceptance
  always @(posedge clk_i) begin
    if (push && !full) begin
      verdict_queue.push_back(suppress_box(in_data_i));
      void'(box_queue.pop_front());
      gap_cycles <= rand_gap();
      push <= 1'b0;
    end else if (!push && gap_cycles > 0) begin
      gap_cycles <= gap_cycles - 1;
    end else if (!push && box_queue.size() > 0 && rst_ni && !send_done) begin
      in_data_i <= box_queue[0];
      push <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      if (verdict_queue.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        cagnms_pkg::out_word_t e;
        e = verdict_queue.pop_front();
        if (out_data_o.kept !== e.kept) report_mismatch("kept", out_data_o.kept, e.kept);
        if (out_data_o.out_left !== e.out_left)
          report_mismatch("left", out_data_o.out_left, e.out_left);
        if (out_data_o.out_top !== e.out_top)
          report_mismatch("top", out_data_o.out_top, e.out_top);
        if (out_data_o.out_right !== e.out_right)
          report_mismatch("right", out_data_o.out_right, e.out_right);
        if (out_data_o.out_bottom !== e.out_bottom)
          report_mismatch("bottom", out_data_o.out_bottom, e.out_bottom);
        if (out_data_o.out_class !== e.out_class)
          report_mismatch("class", out_data_o.out_class, e.out_class);
        if (out_data_o.out_confidence !== e.out_confidence)
          report_mismatch("confidence", out_data_o.out_confidence, e.out_confidence);
        if (out_data_o.kept_count !== e.kept_count)
          report_mismatch("kept_count", out_data_o.kept_count, e.kept_count);
        if (out_data_o.last_of_frame !== e.last_of_frame)
          report_mismatch("last", out_data_o.last_of_frame, e.last_of_frame);
      end
    end
    if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
      pop <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      pop <= 1'b0;
    end else if (pop && !empty) begin
      stall_cycles <= rand_gap();
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(input logic [AB-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == cagnms_pkg::RegThr) thr_q = d[HB-1:0];
    else lim_q = d[LB-1:0];
  endtask

  task automatic add_box(input int l, t, r, b, c, input bit last);
    cagnms_pkg::in_word_t w;
    w.box_left = CB'(l); w.box_top = CB'(t); w.box_right = CB'(r); w.box_bottom = CB'(b);
    w.class_index = KB'(c);
    w.confidence = FB'($urandom_range(0, 65535));
    w.frame_end = last;
    box_queue.push_back(w);
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 40960;
    if (r == 2) return $urandom_range(0, 65535);
    return $urandom_range(0, 40960);
  endfunction

  // frame of clustered boxes with few classes so overlaps hit often
  task automatic add_frame(input int n);
    int cx, cy, w, h;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_box(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                $urandom_range(0, 127), i == n - 1);
      end else begin
        cx = $urandom_range(1000, 3000); cy = $urandom_range(1000, 3000);
        w = $urandom_range(1, 800); h = $urandom_range(1, 800);
        add_box(cx - $urandom_range(0, 200), cy - $urandom_range(0, 200),
                cx + w, cy + h, $urandom_range(0, 3), i == n - 1);
      end
    end
  endtask

  task automatic drain();
    wait (box_queue.size() == 0 && !push);
    wait (verdict_queue.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int f;
    errors = 0; kept_n = 0; stall_cycles = 0; gap_cycles = 0; hold_rx = 0;
    idle_count = 0; send_done = 1'b0;
    thr_q = cagnms_pkg::ThrReset; lim_q = cagnms_pkg::LimReset;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: identical boxes, disjoint, touching edges, inverted, extremes
    add_box(0, 0, 40960, 40960, 0, 0);
    add_box(0, 0, 40960, 40960, 0, 0);
    add_box(0, 0, 40960, 40960, 1, 0);
    add_box(100, 100, 200, 200, 0, 0);
    add_box(200, 100, 300, 200, 2, 0);
    add_box(200, 100, 300, 200, 2, 0);
    add_box(300, 100, 400, 200, 2, 0);
    add_box(500, 500, 400, 400, 3, 0);
    add_box(400, 400, 500, 500, 3, 0);
    add_box(10, 10, 10, 50, 4, 0);
    add_box(65535, 65535, 65535, 65535, 127, 0);
    add_box(0, 0, 65535, 65535, 127, 1);
    drain();

    reg_write(cagnms_pkg::RegThr, 0);
    reg_write(cagnms_pkg::RegLim, 3);
    add_box(0, 0, 100, 100, 5, 0);
    add_box(99, 99, 200, 200, 5, 0);
    add_box(500, 500, 600, 600, 6, 0);
    add_box(700, 700, 800, 800, 6, 0);
    add_box(900, 900, 1000, 1000, 6, 1);
    drain();

    reg_write(cagnms_pkg::RegThr, 256);
    reg_write(cagnms_pkg::RegLim, 0);
    add_box(0, 0, 100, 100, 5, 0);
    add_box(0, 0, 100, 100, 5, 1);
    drain();

    reg_write(cagnms_pkg::RegThr, 511);
    reg_write(cagnms_pkg::RegLim, 1023);
    add_box(0, 0, 100, 100, 5, 0);
    add_box(0, 0, 100, 100, 5, 1);
    add_frame(8);
    drain();

    // long receiver hold-off while sender keeps offering
    reg_write(cagnms_pkg::RegThr, 32'(cagnms_pkg::ThrReset));
    hold_rx = 3000;
    add_frame(12);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          reg_write(cagnms_pkg::RegThr, 179); reg_write(cagnms_pkg::RegLim, 300);
        end
        1: begin
          reg_write(cagnms_pkg::RegThr, 0);   reg_write(cagnms_pkg::RegLim, 5);
        end
        2: begin
          reg_write(cagnms_pkg::RegThr, 128); reg_write(cagnms_pkg::RegLim, 512);
        end
        3: begin
          reg_write(cagnms_pkg::RegThr, 256); reg_write(cagnms_pkg::RegLim, 1);
        end
        4: begin
          reg_write(cagnms_pkg::RegThr, $urandom_range(0, 511));
          reg_write(cagnms_pkg::RegLim, $urandom_range(0, 1023));
        end
        default: begin
          reg_write(cagnms_pkg::RegThr, 64); reg_write(cagnms_pkg::RegLim, 20);
        end
      endcase
      for (f = 0; f < 12; f++) add_frame($urandom_range(1, 30));
      drain();
    end

    // one large frame of disjoint boxes of one class
    reg_write(cagnms_pkg::RegThr, 256);
    reg_write(cagnms_pkg::RegLim, 512);
    for (int i = 0; i < 20; i++)
      add_box(i * 1000, 0, i * 1000 + 10, 10, 9, i == 19);
    drain();

    send_done = 1'b1;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
